// ===== rtl/core/wpma_pkg.sv =====
package wpma_pkg;

    // Field widths of the input and result items.
    localparam int unsigned VAL_W   = 16;
    localparam int unsigned CUR_W   = 14;
    localparam int unsigned PWR_W   = 16;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned S_DATA_W = 32;
    localparam int unsigned M_DATA_W = 48;

    // Reset value of the sample interval register.
    localparam logic [CNT_W-1:0] INTERVAL_RESET = CNT_W'(10);

    // The current is mean * 25 / 100, which is exactly mean / 4.
    localparam int unsigned CUR_SHIFT = 2;

    // Power product of a 16-bit voltage and a 14-bit current.
    localparam int unsigned PROD_W = VAL_W + CUR_W;

    // Exact division by 10000 of a PROD_W-bit value: multiply by the rounded-up
    // reciprocal scaled by 2^(PROD_W + 14) and keep the top bits.
    localparam longint unsigned PWR_DIV     = 64'd10000;
    localparam int unsigned     PWR_SHIFT   = PROD_W + 14;
    localparam longint unsigned PWR_RECIP_L = ((64'd1 << PWR_SHIFT) + PWR_DIV - 64'd1) / PWR_DIV;
    localparam int unsigned     RECIP_W     = 31;
    localparam logic [RECIP_W-1:0] PWR_RECIP = RECIP_W'(PWR_RECIP_L);
    localparam int unsigned     PQ_W        = PROD_W + RECIP_W;
    localparam int unsigned     PWR_Q_W     = PQ_W - PWR_SHIFT;
    localparam logic [PWR_W-1:0] PWR_MAX    = '1;

endpackage

// ===== rtl/core/wpma_cell.sv =====
module wpma_cell
    import wpma_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             shift_en,
    input  logic [VAL_W-1:0] volt_in,
    input  logic [VAL_W-1:0] shunt_in,
    output logic [VAL_W-1:0] volt_out,
    output logic [VAL_W-1:0] shunt_out
);

    logic [VAL_W-1:0] volt_reg;
    logic [VAL_W-1:0] shunt_reg;

    // One window slot: takes the pair from its newer neighbor on a shift.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volt_reg  <= '0;
            shunt_reg <= '0;
        end else if (shift_en) begin
            volt_reg  <= volt_in;
            shunt_reg <= shunt_in;
        end
    end

    assign volt_out  = volt_reg;
    assign shunt_out = shunt_reg;

endmodule

// ===== rtl/core/wpma_window.sv =====
module wpma_window
    import wpma_pkg::*;
#(
    parameter int unsigned WINDOW = 10,
    parameter int unsigned SUM_W  = VAL_W + $clog2(WINDOW)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic             accept,
    input  logic [VAL_W-1:0] volt_new,
    input  logic [VAL_W-1:0] shunt_new,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    output logic             sum_valid,
    output logic [SUM_W-1:0] volt_sum,
    output logic [SUM_W-1:0] shunt_sum
);

    logic [CNT_W-1:0] interval_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [SUM_W-1:0] volt_sum_reg;
    logic [SUM_W-1:0] volt_sum_next;
    logic [SUM_W-1:0] shunt_sum_reg;
    logic [SUM_W-1:0] shunt_sum_next;
    logic             valid_reg;
    logic             take_sample;
    logic             shift_en;

    // Chain taps: index WINDOW holds the incoming pair, index 0 the oldest slot.
    logic [VAL_W-1:0] volt_tap  [WINDOW+1];
    logic [VAL_W-1:0] shunt_tap [WINDOW+1];

    // Interval register, written from the configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= INTERVAL_RESET;
        end else if (cfg_we) begin
            interval_reg <= cfg_wdata;
        end
    end

    // Tick counter decides whether this item enters the windows.
    assign take_sample = (count_reg >= interval_reg);
    assign shift_en    = accept && take_sample;
    assign count_next  = take_sample ? '0 : count_reg + CNT_W'(1);

    assign volt_tap[WINDOW]  = volt_new;
    assign shunt_tap[WINDOW] = shunt_new;

    // Row of window cells, each passing its pair to the older neighbor.
    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        wpma_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_en  (shift_en),
            .volt_in   (volt_tap[i+1]),
            .shunt_in  (shunt_tap[i+1]),
            .volt_out  (volt_tap[i]),
            .shunt_out (shunt_tap[i])
        );
    end

    // Running sums: add the new sample, drop the one leaving the oldest cell.
    assign volt_sum_next  = volt_sum_reg + SUM_W'(volt_new) - SUM_W'(volt_tap[0]);
    assign shunt_sum_next = shunt_sum_reg + SUM_W'(shunt_new) - SUM_W'(shunt_tap[0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            volt_sum_reg  <= '0;
            shunt_sum_reg <= '0;
        end else if (accept) begin
            count_reg <= count_next;
            if (take_sample) begin
                volt_sum_reg  <= volt_sum_next;
                shunt_sum_reg <= shunt_sum_next;
            end
        end
    end

    // Marks that the sums belong to an item that still needs its result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= accept;
        end
    end

    assign sum_valid = valid_reg;
    assign volt_sum  = volt_sum_reg;
    assign shunt_sum = shunt_sum_reg;

endmodule

// ===== rtl/core/wpma_scale.sv =====
module wpma_scale
    import wpma_pkg::*;
#(
    parameter int unsigned WINDOW = 10,
    parameter int unsigned SUM_W  = VAL_W + $clog2(WINDOW)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic                sum_valid,
    input  logic [SUM_W-1:0]    volt_sum,
    input  logic [SUM_W-1:0]    shunt_sum,
    output logic                res_valid,
    output logic [M_DATA_W-1:0] res_data
);

    // Exact floor(sum / WINDOW) for SUM_W-bit sums via a rounded-up reciprocal.
    localparam int unsigned     MEAN_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int unsigned     MW_W       = SUM_W + 1;
    localparam longint unsigned MW_L       =
        ((64'd1 << MEAN_SHIFT) + longint'(WINDOW) - 64'd1) / longint'(WINDOW);
    localparam logic [MW_W-1:0] MEAN_RECIP = MW_W'(MW_L);
    localparam int unsigned     MP_W       = SUM_W + MW_W;

    logic [MP_W-1:0]     volt_prod_reg;
    logic [MP_W-1:0]     shunt_prod_reg;
    logic                v2_reg;
    logic [VAL_W-1:0]    vavg_next;
    logic [CUR_W-1:0]    cur_next;
    logic [VAL_W-1:0]    vavg_reg;
    logic [CUR_W-1:0]    cur_reg;
    logic [PROD_W-1:0]   pprod_reg;
    logic                v3_reg;
    logic [VAL_W-1:0]    vavg4_reg;
    logic [CUR_W-1:0]    cur4_reg;
    logic [PQ_W-1:0]     pq_reg;
    logic                v4_reg;
    logic [PWR_Q_W-1:0]  pwr_q;
    logic [PWR_W-1:0]    pwr_next;
    logic [M_DATA_W-1:0] out_reg;
    logic                out_valid_reg;

    // Stage 2: scale both sums by the window reciprocal.
    always_ff @(posedge aclk) begin
        if (advance) begin
            volt_prod_reg  <= MP_W'(volt_sum) * MP_W'(MEAN_RECIP);
            shunt_prod_reg <= MP_W'(shunt_sum) * MP_W'(MEAN_RECIP);
        end
    end

    // Stage 3: take the means, derive the current and form the power product.
    assign vavg_next = volt_prod_reg[MEAN_SHIFT +: VAL_W];
    assign cur_next  = shunt_prod_reg[MEAN_SHIFT + CUR_SHIFT +: CUR_W];

    always_ff @(posedge aclk) begin
        if (advance) begin
            vavg_reg  <= vavg_next;
            cur_reg   <= cur_next;
            pprod_reg <= PROD_W'(vavg_next) * PROD_W'(cur_next);
        end
    end

    // Stage 4: divide the power product by 10000 through its reciprocal.
    always_ff @(posedge aclk) begin
        if (advance) begin
            vavg4_reg <= vavg_reg;
            cur4_reg  <= cur_reg;
            pq_reg    <= PQ_W'(pprod_reg) * PQ_W'(PWR_RECIP);
        end
    end

    // Stage 5: saturate the power and pack the result item.
    assign pwr_q    = pq_reg[PWR_SHIFT +: PWR_Q_W];
    assign pwr_next = (pwr_q > PWR_Q_W'(PWR_MAX)) ? PWR_MAX : pwr_q[PWR_W-1:0];

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= M_DATA_W'({pwr_next, cur4_reg, vavg4_reg});
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            v2_reg        <= sum_valid;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

endmodule

// ===== rtl/core/windowed_power_monitor_average.sv =====
// Results reach the m_ side via the sum, product, mean, quotient and output registers.
// Throughput: one item per cycle while m_tready stays high; the whole pipeline
// holds when the output register is full and not taken, which also drops s_tready.
// The window cell row with its running sums and the tick counter are the only per-item loops.
// Reset (aresetn low, synchronous) clears both windows, the sums, the interval
// counter and all valid bits, and loads the sample interval with 10.
module windowed_power_monitor_average
    import wpma_pkg::*;
#(
    parameter int unsigned WINDOW = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // bus_voltage_raw[15:0], shunt_raw[31:16]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // bus_voltage_avg[15:0], current_avg[29:16],
                                          // power_est[45:30], zero fill[47:46]
    input  logic                cfg_we,
    input  logic [CNT_W-1:0]    cfg_wdata
);

    localparam int unsigned SUM_W = VAL_W + $clog2(WINDOW);

    logic             advance;
    logic             accept;
    logic             sum_valid;
    logic [SUM_W-1:0] volt_sum;
    logic [SUM_W-1:0] shunt_sum;

    // The pipeline moves whenever the output register is free or being emptied.
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    wpma_window #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .accept    (accept),
        .volt_new  (s_tdata[VAL_W-1:0]),
        .shunt_new (s_tdata[2*VAL_W-1:VAL_W]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sum_valid (sum_valid),
        .volt_sum  (volt_sum),
        .shunt_sum (shunt_sum)
    );

    wpma_scale #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .sum_valid (sum_valid),
        .volt_sum  (volt_sum),
        .shunt_sum (shunt_sum),
        .res_valid (m_tvalid),
        .res_data  (m_tdata)
    );

endmodule

// ===== rtl/core/wpma_checker.sv =====
module wpma_checker
    import wpma_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    logic [63:0] pwr_lhs;
    logic [63:0] prod_rhs;
    logic [63:0] pwr_upper;

    // Power relation of the result fields, checked with multiplications only.
    assign pwr_lhs   = 64'(m_tdata[45:30]) * 64'd10000;
    assign prod_rhs  = 64'(m_tdata[15:0]) * 64'(m_tdata[29:16]);
    assign pwr_upper = (64'(m_tdata[45:30]) + 64'd1) * 64'd10000;

    // A pending result is held until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result item dropped before it was taken");

    // No item enters while the output register is stalled.
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while the output is stalled");

    // Nothing is shown in the cycle after a reset cycle.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Power is the saturated quotient of voltage times current by 10000.
    a_power: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (pwr_lhs <= prod_rhs) &&
                     ((m_tdata[45:30] == PWR_MAX) || (prod_rhs < pwr_upper)) &&
                     (m_tdata[47:46] == 2'b00))
        else $error("power field does not match voltage and current");

endmodule

bind windowed_power_monitor_average wpma_checker u_wpma_checker (.*);
